### sv/mafr_pkg.sv
// shared types and constants for the moving-average frame rate unit
// no dependencies; used by every module of the block

package mafr_pkg;

  // default sizing of the block
  localparam int WINDOW_MAX_DEF = 64;
  localparam int STAMP_BITS_DEF = 32;

  // fixed field widths
  localparam int WIN_CFG_W  = 7;
  localparam int TICK_W     = 32;
  localparam int RATE_W     = 32;
  localparam int INTERVAL_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int FRAC_BITS  = 8;

  // numerator tick_rate * w * 2^FRAC_BITS
  localparam int NUM_W = TICK_W + WIN_CFG_W + FRAC_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK   = 1'b1;

  // register reset values
  localparam logic [WIN_CFG_W-1:0] WIN_RESET  = 7'd8;
  localparam logic [TICK_W-1:0]    TICK_RESET = 32'd1000;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/mafr_ram.sv
// generic single-write, single-read ram with registered read data
// depends on mafr_pkg for default sizing

module mafr_ram #(
  parameter int WIDTH = mafr_pkg::STAMP_BITS_DEF,
  parameter int DEPTH = mafr_pkg::WINDOW_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/mafr_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on mafr_pkg for default widths and the status struct

module mafr_div #(
  parameter int NUM_W = mafr_pkg::NUM_W,
  parameter int DEN_W = mafr_pkg::STAMP_BITS_DEF + $clog2(mafr_pkg::WINDOW_MAX_DEF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output mafr_pkg::div_stat_t stat,
  output logic [NUM_W-1:0]    quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qn_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             take;

  // one compare and subtract step
  always_comb begin
    shifted = {rem_r, qn_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    take    = (shifted >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      qn_r  <= num;
    end else if (busy_r) begin
      rem_r <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      qn_r  <= {qn_r[NUM_W-2:0], take};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = qn_r;

endmodule

### sv/moving_average_frame_rate_unit.sv
// top level of the moving-average frame rate unit: sequencer, ring and total
// depends on mafr_pkg, mafr_ram and mafr_div
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid in_stall in_timestamp | word in
//   out     | out_valid out_stall out_rate   | word out
//           | out_interval                   |
//   cfg     | cfg_we cfg_idx cfg_wdata       | write only
//
// a new nonzero interval: ring read, total and numerator (S_OLD), divider load
// (S_START), one quotient bit per cycle (S_DIV), result (S_FIN), then back to
// S_IDLE for the next word. first word and zero interval go from S_IDLE straight
// to the result. reset clears the ring through valid bits.
// in_stall is high while a word is in work; a stalled result waits in the
// output register and the next word is taken meanwhile.

module moving_average_frame_rate_unit #(
  parameter int WINDOW_MAX = mafr_pkg::WINDOW_MAX_DEF,
  parameter int STAMP_BITS = mafr_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [STAMP_BITS-1:0]           in_timestamp,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mafr_pkg::RATE_W-1:0]     out_rate,
  output logic [mafr_pkg::INTERVAL_W-1:0] out_interval,
  input  logic                            cfg_we,
  input  logic [mafr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mafr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int TOT_W = STAMP_BITS + $clog2(WINDOW_MAX);
  localparam int WIN_W = mafr_pkg::WIN_CFG_W;
  localparam int NUM_W = mafr_pkg::NUM_W;
  localparam int RATE_W = mafr_pkg::RATE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OLD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;

  // configuration
  logic [WIN_W-1:0]        win_r;
  logic [mafr_pkg::TICK_W-1:0] tick_r;

  // block state
  logic [STAMP_BITS-1:0]   last_r;
  logic                    started_r;
  logic [WINDOW_MAX-1:0]   vld_r;
  logic [TOT_W-1:0]        total_r;
  logic [PTR_W-1:0]        ptr_r;

  // work registers
  logic [PTR_W-1:0]        idx_r;
  logic [STAMP_BITS-1:0]   diff_r;
  logic [NUM_W-1:0]        num_r;
  logic [RATE_W-1:0]       res_rate_r;
  logic [mafr_pkg::INTERVAL_W-1:0] res_int_r;

  // output register
  logic                    out_valid_r;
  logic [RATE_W-1:0]       out_rate_r;
  logic [mafr_pkg::INTERVAL_W-1:0] out_int_r;

  logic                    in_acc;
  logic                    out_free;
  logic [WIN_W-1:0]        w_eff;
  logic [PTR_W-1:0]        idx_cur;
  logic [PTR_W-1:0]        ptr_next;
  logic [STAMP_BITS-1:0]   diff_cur;
  logic [STAMP_BITS-1:0]   rd_data;
  logic [STAMP_BITS-1:0]   old_val;
  logic [TOT_W-1:0]        total_nxt;
  logic [NUM_W-1:0]        num_nxt;
  logic [RATE_W-1:0]       rate_sat;
  logic                    div_start;
  mafr_pkg::div_stat_t     div_stat;
  logic [NUM_W-1:0]        div_quot;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // effective window, clamped to 1..WINDOW_MAX
  always_comb begin
    if (win_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (32'(win_r) > WINDOW_MAX) begin
      w_eff = WIN_W'(WINDOW_MAX);
    end else begin
      w_eff = win_r;
    end
  end

  // ring slot for this word and the slot after it
  always_comb begin
    idx_cur  = (32'(ptr_r) >= 32'(w_eff)) ? '0 : ptr_r;
    ptr_next = (32'(idx_r) + 32'd1 >= 32'(w_eff)) ? '0 : PTR_W'(32'(idx_r) + 32'd1);
    diff_cur = in_timestamp - last_r;
  end

  // total update and numerator
  always_comb begin
    old_val   = vld_r[idx_r] ? rd_data : '0;
    total_nxt = total_r - TOT_W'(old_val) + TOT_W'(diff_r);
    num_nxt   = (NUM_W'(tick_r) * NUM_W'(w_eff)) << mafr_pkg::FRAC_BITS;
  end

  // quotient saturation
  always_comb begin
    if (total_r == '0) begin
      rate_sat = '0;
    end else if (|div_quot[NUM_W-1:RATE_W]) begin
      rate_sat = '1;
    end else begin
      rate_sat = div_quot[RATE_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (started_r && (diff_cur != '0)) begin
            state_nxt = S_OLD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_OLD:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign div_start = (state_r == S_START);

  // control state, configuration and ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= mafr_pkg::WIN_RESET;
      tick_r      <= mafr_pkg::TICK_RESET;
      last_r      <= '0;
      started_r   <= 1'b0;
      vld_r       <= '0;
      total_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // configuration writes, expected only while no word is in work
      if (cfg_we) begin
        unique case (cfg_idx)
          mafr_pkg::REG_WINDOW: begin
            win_r   <= cfg_wdata[WIN_W-1:0];
            vld_r   <= '0;
            total_r <= '0;
            ptr_r   <= '0;
          end
          mafr_pkg::REG_TICK: tick_r <= cfg_wdata[mafr_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == S_IDLE) && in_acc) begin
        started_r <= 1'b1;
        last_r    <= in_timestamp;
      end
      // retire the old interval and store the new one
      if (state_r == S_OLD) begin
        total_r      <= total_nxt;
        vld_r[idx_r] <= 1'b1;
        ptr_r        <= ptr_next;
      end
      // output register
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_acc) begin
      idx_r      <= idx_cur;
      diff_r     <= diff_cur;
      res_rate_r <= '0;
      res_int_r  <= started_r ? mafr_pkg::INTERVAL_W'(diff_cur) : '0;
    end
    if (state_r == S_OLD) begin
      num_r <= num_nxt;
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      res_rate_r <= rate_sat;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_rate_r <= res_rate_r;
      out_int_r  <= res_int_r;
    end
  end

  // interval ring
  mafr_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_OLD),
    .waddr (idx_r),
    .wdata (diff_r),
    .raddr (idx_cur),
    .rdata (rd_data)
  );

  // divider for the rate
  mafr_div #(
    .NUM_W (NUM_W),
    .DEN_W (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (total_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign out_valid    = out_valid_r;
  assign out_rate     = out_rate_r;
  assign out_interval = out_int_r;

endmodule
